### src/hysteresis_placement_policy_core_assert.svh
// Assertion macros used by the placement policy decision RTL.
`ifndef HYSTERESIS_PLACEMENT_POLICY_CORE_ASSERT_SVH
`define HYSTERESIS_PLACEMENT_POLICY_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define HPP_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hpp: same-cycle check failed");
// Next-cycle implication, checked outside reset.
`define HPP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hpp: next-cycle check failed");
`else
`define HPP_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define HPP_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### src/hpp_pkg.sv
// Types and constants of the hysteresis placement policy.
package hpp_pkg;

   localparam int unsigned PAGE_SIZE  = 4096;
   localparam int unsigned HOST_COUNT = 4;
   localparam int unsigned NUM_PAGES  = 4;

   localparam int unsigned CAND_HOSTS = (HOST_COUNT < 4) ? HOST_COUNT : 4;
   localparam int unsigned USED_PAGES = (NUM_PAGES < 4) ? NUM_PAGES : 4;

   localparam int unsigned HOST_WIDTH    = 2;
   localparam int unsigned COST_WIDTH    = 15;
   localparam int unsigned CREDIT_WIDTH  = 17;
   localparam int unsigned COUNT_WIDTH   = 16;
   localparam int unsigned MODE_WIDTH    = 2;
   localparam int unsigned MCOST_WIDTH   = 16;
   localparam int unsigned PAGE_CNT_WIDTH = 3;
   localparam int unsigned PRODUCT_WIDTH = 20;
   localparam int unsigned CSR_IDX_WIDTH = 1;

   localparam logic [COST_WIDTH-1:0]   COST_MAX   = 15'h7fff;
   localparam logic [CREDIT_WIDTH-1:0] CREDIT_MAX = 17'h1ffff;
   localparam logic [COUNT_WIDTH-1:0]  COUNT_MAX  = 16'hffff;

   localparam logic [MODE_WIDTH-1:0] MODE_HYSTERESIS = 2'd0;
   localparam logic [MODE_WIDTH-1:0] MODE_GREEDY     = 2'd1;
   localparam logic [MODE_WIDTH-1:0] MODE_STAY       = 2'd2;
   localparam logic [MODE_WIDTH-1:0] MODE_UNUSED     = 2'd3;

   localparam logic [CSR_IDX_WIDTH-1:0] REG_POLICY_MODE = 1'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_THRESHOLD   = 1'd1;

   localparam logic [MODE_WIDTH-1:0]  POLICY_MODE_RESET = MODE_HYSTERESIS;
   localparam logic [MCOST_WIDTH-1:0] THRESHOLD_RESET   = 16'd8192;

   typedef logic [3:0][HOST_WIDTH-1:0] owner_array_type;
   typedef logic [3:0][COST_WIDTH-1:0] cost_array_type;

   typedef struct packed {
      cost_array_type          costs;
      logic [HOST_WIDTH-1:0]   best_host;
      logic [COST_WIDTH-1:0]   best_cost;
   } cost_result_type;

   typedef struct packed {
      logic [HOST_WIDTH-1:0]   target_host;
      logic [COST_WIDTH-1:0]   advantage;
      logic [CREDIT_WIDTH-1:0] credit_now;
      logic                    migrated;
      logic [COUNT_WIDTH-1:0]  migration_total;
   } decision_type;

endpackage

### src/hpp_cost.sv
// Remote cost per host and lowest-cost host selection.
module hpp_cost (
   input  hpp_pkg::owner_array_type owners,
   output hpp_pkg::cost_result_type result
);

   logic [hpp_pkg::PAGE_CNT_WIDTH-1:0] remote_cnt [4];
   logic [hpp_pkg::PRODUCT_WIDTH-1:0]  product [4];
   hpp_pkg::cost_array_type             costs;
   logic [hpp_pkg::HOST_WIDTH-1:0]      best;
   logic [hpp_pkg::COST_WIDTH-1:0]      best_cost;

   // count pages owned elsewhere, scale by page size, saturate
   always_comb begin
      for (int h = 0; h < 4; h++) begin
         remote_cnt[h] = '0;
         for (int j = 0; j < 4; j++) begin
            if (j < hpp_pkg::USED_PAGES && owners[j] != hpp_pkg::HOST_WIDTH'(h)) begin
               remote_cnt[h] = remote_cnt[h] + 1'b1;
            end
         end
         product[h] = hpp_pkg::PRODUCT_WIDTH'(remote_cnt[h])
                      * hpp_pkg::PRODUCT_WIDTH'(hpp_pkg::PAGE_SIZE);
         if (h >= hpp_pkg::CAND_HOSTS) begin
            costs[h] = '0;
         end else if (product[h] > hpp_pkg::PRODUCT_WIDTH'(hpp_pkg::COST_MAX)) begin
            costs[h] = hpp_pkg::COST_MAX;
         end else begin
            costs[h] = product[h][hpp_pkg::COST_WIDTH-1:0];
         end
      end
   end

   // strict less-than keeps the lowest index on ties
   always_comb begin
      best      = '0;
      best_cost = costs[0];
      for (int h = 1; h < 4; h++) begin
         if (h < hpp_pkg::CAND_HOSTS && costs[h] < best_cost) begin
            best      = hpp_pkg::HOST_WIDTH'(h);
            best_cost = costs[h];
         end
      end
   end

   assign result.costs     = costs;
   assign result.best_host = best;
   assign result.best_cost = best_cost;

endmodule

### src/hpp_decide.sv
// Placement decision and policy state (host, streak, migration count).
`include "hysteresis_placement_policy_core_assert.svh"

module hpp_decide (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              enable,
   input  logic [hpp_pkg::MODE_WIDTH-1:0]    policy_mode,
   input  logic [hpp_pkg::MCOST_WIDTH-1:0]   migrate_threshold,
   input  hpp_pkg::cost_result_type          cost,
   output hpp_pkg::decision_type             decision
);

   logic [hpp_pkg::HOST_WIDTH-1:0]   current_host_ff, current_host_in;
   logic [hpp_pkg::HOST_WIDTH-1:0]   streak_host_ff, streak_host_in;
   logic                             streak_valid_ff, streak_valid_in;
   logic [hpp_pkg::CREDIT_WIDTH-1:0] streak_score_ff, streak_score_in;
   logic [hpp_pkg::COUNT_WIDTH-1:0]  migration_count_ff, migration_count_in;

   logic [hpp_pkg::COST_WIDTH-1:0]     cur_cost;
   logic [hpp_pkg::COST_WIDTH-1:0]     adv;
   logic [hpp_pkg::CREDIT_WIDTH:0]     credit_sum;
   logic [hpp_pkg::CREDIT_WIDTH-1:0]   credit_acc;
   logic                               moved;

   assign cur_cost = cost.costs[current_host_ff];
   assign adv = (cur_cost > cost.best_cost) ? cur_cost - cost.best_cost : '0;
   assign credit_sum = {1'b0, streak_score_ff} + (hpp_pkg::CREDIT_WIDTH + 1)'(adv);

   always_comb begin
      if (streak_valid_ff && streak_host_ff == cost.best_host) begin
         credit_acc = (credit_sum > (hpp_pkg::CREDIT_WIDTH + 1)'(hpp_pkg::CREDIT_MAX))
                      ? hpp_pkg::CREDIT_MAX : credit_sum[hpp_pkg::CREDIT_WIDTH-1:0];
      end else begin
         credit_acc = hpp_pkg::CREDIT_WIDTH'(adv);
      end
   end

   always_comb begin
      current_host_in = current_host_ff;
      streak_host_in  = '0;
      streak_valid_in = 1'b0;
      streak_score_in = '0;
      moved           = 1'b0;
      case (policy_mode)
         hpp_pkg::MODE_GREEDY: begin
            if (cost.best_host != current_host_ff) begin
               current_host_in = cost.best_host;
               moved           = 1'b1;
            end
         end
         hpp_pkg::MODE_HYSTERESIS: begin
            if (cost.best_host != current_host_ff && adv != '0) begin
               if (credit_acc > hpp_pkg::CREDIT_WIDTH'(migrate_threshold)) begin
                  current_host_in = cost.best_host;
                  moved           = 1'b1;
               end else begin
                  streak_host_in  = cost.best_host;
                  streak_valid_in = 1'b1;
                  streak_score_in = credit_acc;
               end
            end
         end
         default: begin
            // stay and the unused code hold the host and drop the streak
         end
      endcase
      migration_count_in = migration_count_ff;
      if (moved && migration_count_ff != hpp_pkg::COUNT_MAX) begin
         migration_count_in = migration_count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         current_host_ff    <= '0;
         streak_host_ff     <= '0;
         streak_valid_ff    <= 1'b0;
         streak_score_ff    <= '0;
         migration_count_ff <= '0;
      end else if (enable) begin
         current_host_ff    <= current_host_in;
         streak_host_ff     <= streak_host_in;
         streak_valid_ff    <= streak_valid_in;
         streak_score_ff    <= streak_score_in;
         migration_count_ff <= migration_count_in;
      end
   end

   assign decision.target_host     = current_host_in;
   assign decision.advantage       = adv;
   assign decision.credit_now      = streak_score_in;
   assign decision.migrated        = moved;
   assign decision.migration_total = migration_count_in;

   `HPP_ASSERT_IMPLY(a_move_to_best, clock, reset, enable && moved, current_host_in == cost.best_host)
   `HPP_ASSERT_IMPLY(a_stay_no_move, clock, reset, (policy_mode == hpp_pkg::MODE_STAY || policy_mode == hpp_pkg::MODE_UNUSED), !moved)
   `HPP_ASSERT_IMPLY(a_idle_streak_zero, clock, reset, !streak_valid_ff, streak_score_ff == '0)
   `HPP_ASSERT_NEXT(a_count_step, clock, reset, enable && moved && migration_count_ff != hpp_pkg::COUNT_MAX, migration_count_ff == $past(migration_count_ff) + 16'd1)

endmodule

### src/hysteresis_placement_policy_core.sv
// Top level of the hysteresis placement policy core.
// Path: an accepted request is held in the input stage, then in the response register.
// Throughput: one request per cycle while responses drain; the whole decision, including the credit
//   feedback into the host and streak registers, is combinational between those registers.
// Reset: synchronous, active high; clears pipeline valids, policy state and
//   sets policy_mode to hysteresis and the migration threshold to 8192.
module hysteresis_placement_policy_core (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [hpp_pkg::HOST_WIDTH-1:0]     req_owner_page_a,
   input  logic [hpp_pkg::HOST_WIDTH-1:0]     req_owner_page_b,
   input  logic [hpp_pkg::HOST_WIDTH-1:0]     req_owner_page_c,
   input  logic [hpp_pkg::HOST_WIDTH-1:0]     req_owner_page_d,
   // response channel
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [hpp_pkg::HOST_WIDTH-1:0]     rsp_target_host,
   output logic [hpp_pkg::HOST_WIDTH-1:0]     rsp_best_host,
   output logic [hpp_pkg::COST_WIDTH-1:0]     rsp_cost_host0,
   output logic [hpp_pkg::COST_WIDTH-1:0]     rsp_cost_host1,
   output logic [hpp_pkg::COST_WIDTH-1:0]     rsp_cost_host2,
   output logic [hpp_pkg::COST_WIDTH-1:0]     rsp_cost_host3,
   output logic [hpp_pkg::COST_WIDTH-1:0]     rsp_advantage,
   output logic [hpp_pkg::CREDIT_WIDTH-1:0]   rsp_credit_now,
   output logic                               rsp_migrated,
   output logic [hpp_pkg::COUNT_WIDTH-1:0]    rsp_migration_total,
   // configuration write port
   input  logic                               csr_write_enable,
   input  logic [hpp_pkg::CSR_IDX_WIDTH-1:0]  csr_index,
   input  logic [hpp_pkg::MCOST_WIDTH-1:0]    csr_write_data
);

   // configuration registers
   logic [hpp_pkg::MODE_WIDTH-1:0]  policy_mode_ff;
   logic [hpp_pkg::MCOST_WIDTH-1:0] threshold_ff;

   // input stage: one request held for the decision logic
   logic                     in_valid_ff;
   hpp_pkg::owner_array_type in_owner_ff, in_owner_in;

   // response register
   logic                           rsp_valid_ff;
   hpp_pkg::cost_array_type        rsp_costs_ff;
   logic [hpp_pkg::HOST_WIDTH-1:0] rsp_best_ff;
   hpp_pkg::decision_type          rsp_dec_ff;

   hpp_pkg::cost_result_type cost;
   hpp_pkg::decision_type    decision;
   logic                     rsp_load;

   // The response register loads when it is empty or being drained; the
   // input stage advances in the same cycle, so while a finished response
   // still waits, a request may enter only an empty input stage.
   assign rsp_load  = !rsp_valid_ff || rsp_ready;
   assign req_ready = !in_valid_ff || rsp_load;

   // Register writes: the index selects the target, upper data bits drop
   // for the narrow mode field.
   always_ff @(posedge clock) begin
      if (reset) begin
         policy_mode_ff <= hpp_pkg::POLICY_MODE_RESET;
         threshold_ff   <= hpp_pkg::THRESHOLD_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            hpp_pkg::REG_POLICY_MODE: policy_mode_ff <= csr_write_data[hpp_pkg::MODE_WIDTH-1:0];
            hpp_pkg::REG_THRESHOLD:   threshold_ff   <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   assign in_owner_in[0] = req_owner_page_a;
   assign in_owner_in[1] = req_owner_page_b;
   assign in_owner_in[2] = req_owner_page_c;
   assign in_owner_in[3] = req_owner_page_d;

   // Input stage: capture on accept, drop when passed on with nothing new.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_owner_ff <= in_owner_in;
      end
   end

   hpp_cost u_cost (
      .owners (in_owner_ff),
      .result (cost)
   );

   // Policy state advances only when the held request moves into the
   // response register, so a stalled response never double-counts.
   hpp_decide u_decide (
      .clock             (clock),
      .reset             (reset),
      .enable            (in_valid_ff && rsp_load),
      .policy_mode       (policy_mode_ff),
      .migrate_threshold (threshold_ff),
      .cost              (cost),
      .decision          (decision)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load && in_valid_ff) begin
         rsp_costs_ff <= cost.costs;
         rsp_best_ff  <= cost.best_host;
         rsp_dec_ff   <= decision;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_target_host     = rsp_dec_ff.target_host;
   assign rsp_best_host       = rsp_best_ff;
   assign rsp_cost_host0      = rsp_costs_ff[0];
   assign rsp_cost_host1      = rsp_costs_ff[1];
   assign rsp_cost_host2      = rsp_costs_ff[2];
   assign rsp_cost_host3      = rsp_costs_ff[3];
   assign rsp_advantage       = rsp_dec_ff.advantage;
   assign rsp_credit_now      = rsp_dec_ff.credit_now;
   assign rsp_migrated        = rsp_dec_ff.migrated;
   assign rsp_migration_total = rsp_dec_ff.migration_total;

endmodule
